// ----- hw/rtl/flow_value_color_spiral_defines.svh -----
// assertion macros for the flow value color spiral
// included by the files that carry concurrent checks; needs clk and rst in scope
`ifndef FLOW_VALUE_COLOR_SPIRAL_DEFINES_SVH
`define FLOW_VALUE_COLOR_SPIRAL_DEFINES_SVH

// same-cycle implication, quiet during reset
`define CLRSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define CLRSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/clrsp_pkg.sv -----
// shared types and constants of the flow value color spiral
// no dependencies
`default_nettype none

package clrsp_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int VALUE_W = 24;
  localparam int CFG_IDX_W = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_PERIOD = 2'd2;

  localparam logic [7:0] FIXED_PERIOD = 8'd5;
  localparam logic [VALUE_W-1:0] VALUE_MAX_RESET = VALUE_W'(65280);
  localparam logic [7:0] HUE_PERIOD_RESET = 8'd5;

  // no-match marker, -9999 in the value format
  localparam longint MARKER_L = -(longint'(9999) <<< FRACTION_BITS);
  localparam logic MARKER_FITS = (MARKER_L >= -(longint'(1) <<< (VALUE_W - 1)));
  localparam logic [63:0] MARKER_BITS = MARKER_L;
  localparam logic [VALUE_W-1:0] MARKER = MARKER_BITS[VALUE_W-1:0];

  // brightness ramp, 16-bit fractions
  localparam logic [16:0] BRIGHT_OFFSET = 17'd6553;
  localparam logic [15:0] BRIGHT_LOW = 16'd16384;
  localparam logic [15:0] BRIGHT_HIGH = 16'd49152;
  localparam logic [16:0] ONE16 = 17'h10000;

  // divider pipeline shape
  localparam int DIV_STAGES = 8;
  localparam int DIFF_W = VALUE_W + 1;
  localparam int D_W = DIFF_W + 4;
  localparam int REM_W = D_W + 1;
  localparam int SAT_STEPS = 16 / DIV_STAGES;
  localparam int HUE_SHIFT = 16 - FRACTION_BITS;
  localparam int HUE_X_W = VALUE_W + HUE_SHIFT;
  localparam int HUE_STEPS = (HUE_X_W + DIV_STAGES - 1) / DIV_STAGES;
  localparam int HUE_U_W = HUE_STEPS * DIV_STAGES;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sample_value;
    logic channel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic matched;
  } out_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_min;
    logic signed [VALUE_W-1:0] value_max;
    logic [7:0] hue_period;
  } cfg_t;

  // state of one item while both divisions run
  typedef struct packed {
    logic nomatch;
    logic sat_low;
    logic sat_high;
    logic [REM_W-1:0] sat_rem;
    logic [D_W-1:0] sat_den;
    logic [15:0] sat_q;
    logic hue_neg;
    logic [HUE_U_W-1:0] hue_num;
    logic [7:0] hue_per;
    logic [7:0] hue_rem;
    logic [15:0] hue_q;
  } div_t;

endpackage

`default_nettype wire

// ----- hw/rtl/clrsp_front.sv -----
// input register and operand preparation for both divisions
// depends on clrsp_pkg
`default_nettype none

module clrsp_front import clrsp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire in_item_t in_item,
  input  wire cfg_t cfg,
  output logic out_valid,
  output div_t out_data
);

  logic s1_valid;
  in_item_t s1_item;

  logic s2_valid;
  logic s2_nomatch;
  logic signed [VALUE_W-1:0] s2_v;
  logic [7:0] s2_per;
  logic signed [DIFF_W-1:0] s2_diff;
  logic signed [DIFF_W-1:0] s2_den;

  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] den;
  logic [7:0] per;

  logic [DIFF_W-1:0] diff_mag;
  logic [DIFF_W-1:0] den_mag;
  logic [D_W-1:0] num_a;
  logic [D_W-1:0] den_a;
  logic sat_low;
  logic signed [HUE_X_W-1:0] hue_x;
  logic signed [HUE_X_W-1:0] hue_u;

  assign diff = DIFF_W'(s1_item.sample_value) - DIFF_W'(cfg.value_min);
  assign den = DIFF_W'(cfg.value_max) - DIFF_W'(cfg.value_min);

  always_comb begin
    if (s1_item.channel) begin
      per = FIXED_PERIOD;
    end else if (cfg.hue_period == 8'd0) begin
      per = 8'd1;
    end else begin
      per = cfg.hue_period;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
    if (en) begin
      s1_item <= in_item;
      s2_nomatch <= MARKER_FITS && (s1_item.sample_value == MARKER);
      s2_v <= s1_item.sample_value;
      s2_per <= per;
      s2_diff <= diff;
      s2_den <= den;
    end
  end

  // magnitudes; the most negative pattern reads correctly as unsigned
  assign diff_mag = s2_diff[DIFF_W-1] ? DIFF_W'(-s2_diff) : DIFF_W'(s2_diff);
  assign den_mag = s2_den[DIFF_W-1] ? DIFF_W'(-s2_den) : DIFF_W'(s2_den);
  assign num_a = {diff_mag, 3'b000} + D_W'(diff_mag);
  assign den_a = D_W'({den_mag, 3'b000}) + D_W'({den_mag, 1'b0});

  // zero span, zero offset or a negative ratio all land on the low clamp
  assign sat_low = (s2_den == '0) || (s2_diff == '0) ||
                   (s2_diff[DIFF_W-1] != s2_den[DIFF_W-1]);

  // floor(x / p) = ~floor(~x / p) for negative x
  assign hue_x = HUE_X_W'(s2_v) <<< HUE_SHIFT;
  assign hue_u = hue_x[HUE_X_W-1] ? ~hue_x : hue_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid;
    end
    if (en) begin
      out_data.nomatch <= s2_nomatch;
      out_data.sat_low <= sat_low;
      out_data.sat_high <= !sat_low && (num_a >= den_a);
      out_data.sat_rem <= REM_W'(num_a);
      out_data.sat_den <= den_a;
      out_data.sat_q <= '0;
      out_data.hue_neg <= hue_x[HUE_X_W-1];
      out_data.hue_num <= HUE_U_W'($unsigned(hue_u));
      out_data.hue_per <= s2_per;
      out_data.hue_rem <= '0;
      out_data.hue_q <= '0;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/clrsp_div_stage.sv -----
// one stage of the two restoring dividers (brightness ratio and hue fraction)
// depends on clrsp_pkg
`default_nettype none

module clrsp_div_stage import clrsp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire div_t in_data,
  output logic out_valid,
  output div_t out_data
);

  div_t nxt;
  logic [REM_W-1:0] sat_shift;
  logic [8:0] hue_shift;
  logic [8:0] hue_diff;

  always_comb begin
    nxt = in_data;
    sat_shift = '0;
    hue_shift = '0;
    hue_diff = '0;
    for (int i = 0; i < SAT_STEPS; i++) begin
      sat_shift = {nxt.sat_rem[REM_W-2:0], 1'b0};
      if (sat_shift >= REM_W'(nxt.sat_den)) begin
        nxt.sat_rem = sat_shift - REM_W'(nxt.sat_den);
        nxt.sat_q = {nxt.sat_q[14:0], 1'b1};
      end else begin
        nxt.sat_rem = sat_shift;
        nxt.sat_q = {nxt.sat_q[14:0], 1'b0};
      end
    end
    // only the low 16 quotient bits are kept: the hue wraps at one
    for (int j = 0; j < HUE_STEPS; j++) begin
      hue_shift = {nxt.hue_rem, nxt.hue_num[HUE_U_W-1]};
      nxt.hue_num = {nxt.hue_num[HUE_U_W-2:0], 1'b0};
      hue_diff = hue_shift - {1'b0, nxt.hue_per};
      if (hue_shift >= {1'b0, nxt.hue_per}) begin
        nxt.hue_rem = hue_diff[7:0];
        nxt.hue_q = {nxt.hue_q[14:0], 1'b1};
      end else begin
        nxt.hue_rem = hue_shift[7:0];
        nxt.hue_q = {nxt.hue_q[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_data <= nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/clrsp_hsv.sv -----
// brightness clamp, hsv sextant rule and byte scaling, three register stages
// depends on clrsp_pkg
`default_nettype none

module clrsp_hsv import clrsp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire div_t in_data,
  output logic out_valid,
  output out_item_t out_item
);

  function automatic logic [7:0] to_byte(input logic [16:0] c);
    logic [24:0] t;
    t = {c, 8'b0} - {8'b0, c};
    return t[23:16];
  endfunction

  logic [16:0] q_plus;
  logic [15:0] s16;
  logic [15:0] h16;
  logic [18:0] h6;
  logic [16:0] f2;
  logic [16:0] d;

  logic h1_valid;
  logic h1_nomatch;
  logic [15:0] h1_s16;
  logic [2:0] h1_sext;
  logic [16:0] h1_w;

  logic [32:0] prod;
  logic h2_valid;
  logic h2_nomatch;
  logic [15:0] h2_s16;
  logic [2:0] h2_sext;
  logic [15:0] h2_x16;

  logic [16:0] cmin;
  logic [16:0] cmid;
  logic [16:0] rr;
  logic [16:0] gg;
  logic [16:0] bb;

  assign q_plus = {1'b0, in_data.sat_q} + BRIGHT_OFFSET;

  always_comb begin
    if (in_data.sat_low) begin
      s16 = BRIGHT_LOW;
    end else if (in_data.sat_high || (q_plus > 17'(BRIGHT_HIGH))) begin
      s16 = BRIGHT_HIGH;
    end else if (q_plus < 17'(BRIGHT_LOW)) begin
      s16 = BRIGHT_LOW;
    end else begin
      s16 = q_plus[15:0];
    end
  end

  assign h16 = in_data.hue_neg ? ~in_data.hue_q : in_data.hue_q;
  assign h6 = {1'b0, h16, 2'b00} + {2'b00, h16, 1'b0};
  assign f2 = h6[16:0];
  assign d = (f2 >= ONE16) ? (f2 - ONE16) : (ONE16 - f2);

  always_ff @(posedge clk) begin
    if (rst) begin
      h1_valid <= 1'b0;
    end else if (en) begin
      h1_valid <= in_valid;
    end
    if (en) begin
      h1_nomatch <= in_data.nomatch;
      h1_s16 <= s16;
      h1_sext <= h6[18:16];
      h1_w <= ONE16 - d;
    end
  end

  assign prod = {1'b0, h1_s16} * {16'b0, h1_w};

  always_ff @(posedge clk) begin
    if (rst) begin
      h2_valid <= 1'b0;
    end else if (en) begin
      h2_valid <= h1_valid;
    end
    if (en) begin
      h2_nomatch <= h1_nomatch;
      h2_s16 <= h1_s16;
      h2_sext <= h1_sext;
      h2_x16 <= prod[31:16];
    end
  end

  assign cmin = ONE16 - {1'b0, h2_s16};
  assign cmid = cmin + {1'b0, h2_x16};

  always_comb begin
    case (h2_sext)
      3'd0: begin rr = ONE16; gg = cmid; bb = cmin; end
      3'd1: begin rr = cmid; gg = ONE16; bb = cmin; end
      3'd2: begin rr = cmin; gg = ONE16; bb = cmid; end
      3'd3: begin rr = cmin; gg = cmid; bb = ONE16; end
      3'd4: begin rr = cmid; gg = cmin; bb = ONE16; end
      default: begin rr = ONE16; gg = cmin; bb = cmid; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= h2_valid;
    end
    if (en) begin
      if (h2_nomatch) begin
        out_item <= '0;
      end else begin
        out_item.blue <= to_byte(bb);
        out_item.green <= to_byte(gg);
        out_item.red <= to_byte(rr);
        out_item.matched <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/flow_value_color_spiral.sv -----
// Flow value color spiral: colors one signed Q15.8 flow or disparity value
// per item on a hue spiral, returning 8-bit blue, green, red and a match flag.
// Input channel in_valid/in_ready/in_item; output channel out_valid/out_ready/
// out_item; configuration by cfg_we/cfg_index/cfg_data (0 value_min,
// 1 value_max, 2 hue_period), to be written by the user only while no item
// is in flight; the block does not enforce it. There are 14 register stages:
// three front stages, eight divider stages, three color stages. Throughput is
// one item per cycle unless the receiver stalls; the divider chain resolves
// two brightness bits and four hue bits per stage, which sets the depth.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops in the same cycle; nothing is lost.
// Reset clears all valid bits and loads value_min 0, value_max 255.0 and
// hue_period 5; the block takes items in the first cycle after reset.
// depends on clrsp_pkg, clrsp_front, clrsp_div_stage, clrsp_hsv, flow_value_color_spiral_defines.svh
`default_nettype none

`include "flow_value_color_spiral_defines.svh"

module flow_value_color_spiral import clrsp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire in_item_t in_item,
  output logic out_valid,
  input  wire logic out_ready,
  output out_item_t out_item,
  input  wire logic cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [VALUE_W-1:0] cfg_data
);

  cfg_t cfg;
  logic en;
  logic div_valid [0:DIV_STAGES];
  div_t div_data [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.value_min <= '0;
      cfg.value_max <= VALUE_MAX_RESET;
      cfg.hue_period <= HUE_PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VALUE_MIN: cfg.value_min <= cfg_data;
        REG_VALUE_MAX: cfg.value_max <= cfg_data;
        REG_HUE_PERIOD: cfg.hue_period <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // the pipeline moves unless a result waits on a stalled receiver
  assign en = !(out_valid && !out_ready);
  assign in_ready = en;

  clrsp_front u_front (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(in_valid),
    .in_item(in_item),
    .cfg(cfg),
    .out_valid(div_valid[0]),
    .out_data(div_data[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    clrsp_div_stage u_stage (
      .clk(clk),
      .rst(rst),
      .en(en),
      .in_valid(div_valid[g]),
      .in_data(div_data[g]),
      .out_valid(div_valid[g+1]),
      .out_data(div_data[g+1])
    );
  end

  clrsp_hsv u_hsv (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(div_valid[DIV_STAGES]),
    .in_data(div_data[DIV_STAGES]),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  `CLRSP_ASSERT_NOW(a_nomatch_black, out_valid && !out_item.matched,
    (out_item.red == 8'd0) && (out_item.green == 8'd0) && (out_item.blue == 8'd0),
    "unmatched item is not black")

  `CLRSP_ASSERT_NOW(a_full_channel, out_valid && out_item.matched,
    (out_item.red == 8'd255) || (out_item.green == 8'd255) || (out_item.blue == 8'd255),
    "matched item has no full channel")

  `CLRSP_ASSERT_NOW(a_floor_channel, out_valid && out_item.matched,
    (out_item.red >= 8'd63) && (out_item.green >= 8'd63) && (out_item.blue >= 8'd63),
    "channel below the saturation floor")

  `CLRSP_ASSERT_NEXT(a_stall_freeze, out_valid && !out_ready && !rst,
    out_valid && $stable(div_valid[DIV_STAGES]), "pipeline moved during a stall")

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// testbench for flow_value_color_spiral: directed table then random values, each result
// checked against its row's own expectation or a fixed-point color predictor; depends on clrsp_pkg
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import clrsp_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 0;
  out_item_t out_item;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VALUE_W-1:0] cfg_data = '0;

  flow_value_color_spiral u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor copy of the registers
  longint ramp_lo, ramp_hi;
  int unsigned spiral_period;
  out_item_t color_queue[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 0;

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && ((a < 0) != (b < 0))) q--;
    return q;
  endfunction

  function automatic out_item_t color_of(in_item_t it);
    out_item_t o;
    longint v, den, s, per, r;
    longint unsigned h, h6, f2, d, x, cmin, cmid, rr, gg, bb;
    v = longint'(it.sample_value);
    o = '0;
    if (MARKER_FITS && v == MARKER_L) return o;
    den = ramp_hi - ramp_lo;
    if (den == 0) s = 16384;
    else begin
      s = fdiv((v - ramp_lo) * 9 * 65536, den * 10) + 6553;
      if (s > 49152) s = 49152;
      if (s < 16384) s = 16384;
    end
    per = it.channel ? 5 : spiral_period;
    if (per == 0) per = 1;
    per = per << FRACTION_BITS;
    r = v % per;
    if (r < 0) r += per;
    h = ((r * 65536) / per) & 16'hffff;
    h6 = h * 6;
    f2 = h6 & 17'h1ffff;
    d = (f2 >= 65536) ? f2 - 65536 : 65536 - f2;
    x = (longint'(s) * (65536 - d)) >> 16;
    cmin = 65536 - s;
    cmid = cmin + x;
    case (h6 >> 16)
      0: begin rr = 65536; gg = cmid; bb = cmin; end
      1: begin rr = cmid; gg = 65536; bb = cmin; end
      2: begin rr = cmin; gg = 65536; bb = cmid; end
      3: begin rr = cmin; gg = cmid; bb = 65536; end
      4: begin rr = cmid; gg = cmin; bb = 65536; end
      default: begin rr = 65536; gg = cmin; bb = cmid; end
    endcase
    o.blue = 8'((bb * 255) >> 16);
    o.green = 8'((gg * 255) >> 16);
    o.red = 8'((rr * 255) >> 16);
    o.matched = 1'b1;
    return o;
  endfunction

  // receiver with stalls and a long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (color_queue.size() == 0) begin
          $display("%0t unexpected result %p", $time, out_item);
          errors++;
        end else begin
          out_item_t want;
          want = color_queue.pop_front();
          if (out_item !== want) begin
            $display("%0t mismatch expected %p actual %p", $time, want, out_item);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // leaves cfg_we high; the caller drops it after its last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_VALUE_MIN: ramp_lo = longint'($signed(val));
      REG_VALUE_MAX: ramp_hi = longint'($signed(val));
      default: spiral_period = val[7:0];
    endcase
  endtask

  // one item, with an expectation of its own or from the predictor
  task automatic send_value(in_item_t it, bit typed, out_item_t typed_exp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_item <= it;
    color_queue.push_back(typed ? typed_exp : color_of(it));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (color_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    int sel;
    sel = $urandom_range(9);
    it.channel = 1'($urandom_range(1));
    if (sel < 6) it.sample_value = 24'($signed($urandom_range(8192)) - 4096);
    else if (sel < 7) it.sample_value = MARKER;
    else it.sample_value = 24'($urandom);
    return it;
  endfunction

  typedef struct {
    logic [VALUE_W-1:0] val;
    logic chan;
    bit typed;
    out_item_t res;
  } stim_row_t;

  stim_row_t directed[] = '{
    '{MARKER, 0, 1, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{MARKER, 1, 1, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{24'd0, 0, 1, '{8'd191, 8'd191, 8'd255, 1'b1}},
    '{24'd0, 1, 1, '{8'd191, 8'd191, 8'd255, 1'b1}},
    '{24'd65280, 0, 0, '0},
    '{24'h7fffff, 0, 0, '0},
    '{24'h800000, 0, 0, '0},
    '{24'h7fffff, 1, 0, '0},
    '{24'h800000, 1, 0, '0},
    '{24'hffffff, 0, 0, '0},
    '{24'd1279, 0, 0, '0},
    '{24'd1280, 1, 0, '0},
    '{24'd640, 0, 0, '0},
    '{24'hfffb00, 1, 0, '0},
    '{24'h555555, 0, 0, '0},
    '{24'haaaaaa, 1, 0, '0}
  };

  initial begin
    int n;
    ramp_lo = 0; ramp_hi = 65280; spiral_period = 5;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed[i])
      send_value('{directed[i].val, directed[i].chan}, directed[i].typed, directed[i].res);
    drain();
    // long hold-off so the pipe fills and stalls input
    hold_off = 1;
    fork
      begin repeat (60) @(posedge clk); hold_off = 0; end
      repeat (40) send_value(rand_item(), 0, '0);
    join
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_VALUE_MIN, 24'h800000); write_reg(REG_VALUE_MAX, 24'h7fffff);
                 write_reg(REG_HUE_PERIOD, 8'd255); end
        1: begin write_reg(REG_VALUE_MIN, 24'd1000); write_reg(REG_VALUE_MAX, 24'd1000);
                 write_reg(REG_HUE_PERIOD, 8'd1); end
        2: begin write_reg(REG_VALUE_MIN, 24'd2000); write_reg(REG_VALUE_MAX, 24'hfff000);
                 write_reg(REG_HUE_PERIOD, 8'd0); end
        3: begin write_reg(REG_VALUE_MIN, 24'h7fffff); write_reg(REG_VALUE_MAX, 24'h800000);
                 write_reg(REG_HUE_PERIOD, 8'd7); end
        default: begin write_reg(REG_VALUE_MIN, 24'($signed($urandom_range(8192)) - 4096));
                 write_reg(REG_VALUE_MAX, 24'($urandom_range(8192)));
                 write_reg(REG_HUE_PERIOD, 8'($urandom)); end
      endcase
      cfg_we <= 0;
      for (int k = 0; k < 4; k++) begin
        case (k)
          0: begin send_idle_pct = 0; recv_stall_pct = 0; end
          1: begin send_idle_pct = 63; recv_stall_pct = 0; end
          2: begin send_idle_pct = 0; recv_stall_pct = 63; end
          default: begin send_idle_pct = 15; recv_stall_pct = 15; end
        endcase
        n = 42;
        repeat (n) send_value(rand_item(), 0, '0);
      end
      drain();
    end
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/clrsp_pkg.sv
hw/rtl/clrsp_front.sv
hw/rtl/clrsp_div_stage.sv
hw/rtl/clrsp_hsv.sv
hw/rtl/flow_value_color_spiral.sv
test/tb_top.sv
